/* hdl/token_bucket_waiter_queue_defines.svh */
// Assertion macros shared by the token bucket waiter queue RTL.
`ifndef TOKEN_BUCKET_WAITER_QUEUE_DEFINES_SVH
`define TOKEN_BUCKET_WAITER_QUEUE_DEFINES_SVH

`ifndef SYNTHESIS

// Check that a property holds at every clock edge outside reset.
`define TBWQ_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Check that a condition never occurs outside reset.
`define TBWQ_NEVER(lbl, clk, rst, cond, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) !(cond)) else $error(msg);

`else

`define TBWQ_ASSERT(lbl, clk, rst, prop, msg)
`define TBWQ_NEVER(lbl, clk, rst, cond, msg)

`endif

`endif

/* hdl/tbwq_pkg.sv */
// Types, constants and codes shared by the token bucket waiter queue.
`timescale 1ns / 1ps

package tbwq_pkg;

   localparam int QUEUE_DEPTH = 16;
   localparam int ID_BITS     = 8;
   localparam int PTR_BITS    = $clog2(QUEUE_DEPTH);
   localparam int FILL_BITS   = $clog2(QUEUE_DEPTH + 1);

   localparam logic [1:0] CMD_TICK    = 2'd0;
   localparam logic [1:0] CMD_REQUEST = 2'd1;
   localparam logic [1:0] CMD_STOP    = 2'd2;

   localparam logic [1:0] ST_GRANTED   = 2'd0;
   localparam logic [1:0] ST_CANCELLED = 2'd1;
   localparam logic [1:0] ST_REJECTED  = 2'd2;

   localparam logic [7:0] TOKEN_CAP_RESET = 8'd2;

   typedef struct packed {
      logic [1:0] cmd;
      logic [7:0] requester_id;
   } req_type;

   typedef struct packed {
      logic [7:0] granted_id;
      logic [1:0] status;
      logic       last;
   } rsp_type;

   typedef struct packed {
      logic empty;
      logic full;
   } fifo_status_type;

endpackage

/* hdl/tbwq_fifo.sv */
// Waiter queue: circular buffer of requester ids with registered read.
`timescale 1ns / 1ps
`include "token_bucket_waiter_queue_defines.svh"

module tbwq_fifo (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          push,
   input  logic [tbwq_pkg::ID_BITS-1:0]  push_id,
   input  logic                          pop,
   output logic [tbwq_pkg::ID_BITS-1:0]  rd_id,
   output tbwq_pkg::fifo_status_type     status
);

   logic [tbwq_pkg::ID_BITS-1:0]   mem [tbwq_pkg::QUEUE_DEPTH];
   logic [tbwq_pkg::ID_BITS-1:0]   rd_id_ff;
   logic [tbwq_pkg::PTR_BITS-1:0]  head_ff;
   logic [tbwq_pkg::PTR_BITS-1:0]  head_in;
   logic [tbwq_pkg::PTR_BITS-1:0]  tail_ff;
   logic [tbwq_pkg::PTR_BITS-1:0]  tail_in;
   logic [tbwq_pkg::FILL_BITS-1:0] fill_ff;
   logic [tbwq_pkg::FILL_BITS-1:0] fill_in;

   localparam logic [tbwq_pkg::PTR_BITS-1:0] LastSlot =
      tbwq_pkg::PTR_BITS'(tbwq_pkg::QUEUE_DEPTH - 1);

   // Advance pointers with wrap at the queue depth
   always_comb begin
      head_in = head_ff;
      tail_in = tail_ff;
      fill_in = fill_ff;
      if (pop) begin
         head_in = (head_ff == LastSlot) ? '0 : head_ff + 1'b1;
         fill_in = fill_in - 1'b1;
      end
      if (push) begin
         tail_in = (tail_ff == LastSlot) ? '0 : tail_ff + 1'b1;
         fill_in = fill_in + 1'b1;
      end
   end

   // Hold pointers and fill count
   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff <= '0;
         tail_ff <= '0;
         fill_ff <= '0;
      end else begin
         head_ff <= head_in;
         tail_ff <= tail_in;
         fill_ff <= fill_in;
      end
   end

   // Write at tail, read at head into the output register
   always_ff @(posedge clock) begin
      if (push) begin
         mem[tail_ff] <= push_id;
      end
      if (pop) begin
         rd_id_ff <= mem[head_ff];
      end
   end

   assign rd_id        = rd_id_ff;
   assign status.empty = (fill_ff == '0);
   assign status.full  = (fill_ff == tbwq_pkg::FILL_BITS'(tbwq_pkg::QUEUE_DEPTH));

   `TBWQ_NEVER(a_pop_empty, clock, reset, pop && status.empty, "pop from empty queue")
   `TBWQ_NEVER(a_push_full, clock, reset, push && status.full, "push into full queue")
   `TBWQ_NEVER(a_push_pop, clock, reset, push && pop, "push and pop in one cycle")

endmodule

/* hdl/token_bucket_waiter_queue.sv */
// Token bucket rate limiter with a queue of waiting requesters.
//
// Usage: drive req_data and raise start; the command is taken at a clock
// edge where start is high and busy is low. Unless stopped, cmd tick adds
// one token up to the token cap and then grants queued requesters in order;
// cmd request is granted, queued or rejected; cmd stop cancels every queued
// requester and rejects all later requests. Each answer appears on rsp_data
// for exactly one cycle with rsp_valid high; rsp_data.last marks the final
// answer of a command. The receiver cannot stall, so answers are never held
// back. Rate: a request answered at once shows its result in the cycle after
// acceptance and the block stays ready, so such commands run one per cycle.
// A tick or stop that drains the queue pops the head waiter into the registered
// read in S_READ, where a grant takes the shared token decrement, then shows
// the answer in S_EMIT, for each answer, and keeps busy high meanwhile.
// The token cap is written on the csr channel while the block is idle.
// Reset clears the token count, empties the queue, clears the stop state
// and loads the token cap with 2.
`timescale 1ns / 1ps
`include "token_bucket_waiter_queue_defines.svh"

module token_bucket_waiter_queue (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   output logic              busy,
   input  tbwq_pkg::req_type req_data,
   output logic              rsp_valid,
   output tbwq_pkg::rsp_type rsp_data,
   input  logic              csr_valid,
   output logic              csr_ready,
   input  logic [7:0]        csr_data
);

   typedef enum logic [1:0] {
      S_IDLE,
      S_READ,
      S_EMIT
   } state_type;

   state_type                    state_ff, state_in;
   logic [7:0]                   token_cap_ff, token_cap_in;
   logic [7:0]                   token_ff, token_in;
   logic                         stopped_ff, stopped_in;
   logic                         cancel_ff, cancel_in;
   logic                         rsp_valid_ff, rsp_valid_in;
   tbwq_pkg::rsp_type            rsp_data_ff, rsp_data_in;

   logic                         accept;
   logic [8:0]                   token_inc;
   logic [7:0]                   token_sat;
   logic [7:0]                   token_dec;
   logic                         fifo_push;
   logic                         fifo_pop;
   logic [tbwq_pkg::ID_BITS-1:0] req_id;
   logic [tbwq_pkg::ID_BITS-1:0] rd_id;
   tbwq_pkg::fifo_status_type    fifo_status;

   tbwq_fifo u_fifo (
      .clock   (clock),
      .reset   (reset),
      .push    (fifo_push),
      .push_id (req_id),
      .pop     (fifo_pop),
      .rd_id   (rd_id),
      .status  (fifo_status)
   );

   assign busy      = (state_ff != S_IDLE);
   assign accept    = start && !busy;
   assign csr_ready = !busy;
   assign req_id    = tbwq_pkg::ID_BITS'(req_data.requester_id);

   // Shared token arithmetic: saturating increment and single decrement
   assign token_inc = {1'b0, token_ff} + 9'd1;
   assign token_sat = (token_inc < {1'b0, token_cap_ff}) ? token_inc[7:0] : token_cap_ff;
   assign token_dec = token_ff - 8'd1;

   // Sequence commands and drains
   always_comb begin
      state_in      = state_ff;
      token_cap_in  = token_cap_ff;
      token_in      = token_ff;
      stopped_in    = stopped_ff;
      cancel_in     = cancel_ff;
      rsp_valid_in  = 1'b0;
      rsp_data_in   = rsp_data_ff;
      fifo_push     = 1'b0;
      fifo_pop      = 1'b0;

      if (csr_valid && csr_ready) begin
         token_cap_in = csr_data;
      end

      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               case (req_data.cmd)
                  tbwq_pkg::CMD_TICK: begin
                     if (!stopped_ff) begin
                        token_in  = token_sat;
                        cancel_in = 1'b0;
                        if (!fifo_status.empty && token_sat != 8'd0) begin
                           state_in = S_READ;
                        end
                     end
                  end
                  tbwq_pkg::CMD_REQUEST: begin
                     rsp_data_in.granted_id = 8'(req_id);
                     rsp_data_in.last       = 1'b1;
                     if (stopped_ff) begin
                        rsp_valid_in       = 1'b1;
                        rsp_data_in.status = tbwq_pkg::ST_REJECTED;
                     end else if (fifo_status.empty && token_ff != 8'd0) begin
                        token_in           = token_dec;
                        rsp_valid_in       = 1'b1;
                        rsp_data_in.status = tbwq_pkg::ST_GRANTED;
                     end else if (!fifo_status.full) begin
                        fifo_push = 1'b1;
                     end else begin
                        rsp_valid_in       = 1'b1;
                        rsp_data_in.status = tbwq_pkg::ST_REJECTED;
                     end
                  end
                  tbwq_pkg::CMD_STOP: begin
                     stopped_in = 1'b1;
                     cancel_in  = 1'b1;
                     if (!fifo_status.empty) begin
                        state_in = S_READ;
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end
         S_READ: begin
            // Pop the head waiter; a grant spends one token
            fifo_pop = 1'b1;
            if (!cancel_ff) begin
               token_in = token_dec;
            end
            state_in = S_EMIT;
         end
         S_EMIT: begin
            // Emit the popped waiter and decide whether the drain goes on
            rsp_valid_in           = 1'b1;
            rsp_data_in.granted_id = 8'(rd_id);
            rsp_data_in.status     = cancel_ff ? tbwq_pkg::ST_CANCELLED
                                               : tbwq_pkg::ST_GRANTED;
            rsp_data_in.last       = fifo_status.empty || (!cancel_ff && token_ff == 8'd0);
            state_in               = rsp_data_in.last ? S_IDLE : S_READ;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // Hold state and registered outputs
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         token_cap_ff  <= tbwq_pkg::TOKEN_CAP_RESET;
         token_ff      <= '0;
         stopped_ff    <= 1'b0;
         cancel_ff     <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         token_cap_ff  <= token_cap_in;
         token_ff      <= token_in;
         stopped_ff    <= stopped_in;
         cancel_ff     <= cancel_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   // Hold result payload
   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   `TBWQ_ASSERT(a_cancel_stopped, clock, reset,
      rsp_valid && rsp_data.status == tbwq_pkg::ST_CANCELLED |-> stopped_ff,
      "cancel result while not stopped")
   `TBWQ_ASSERT(a_emit_strobe, clock, reset,
      state_ff == S_EMIT |=> rsp_valid,
      "drain step produced no result")
   `TBWQ_ASSERT(a_stopped_tick, clock, reset,
      accept && stopped_ff && req_data.cmd == tbwq_pkg::CMD_TICK |=> !rsp_valid && !busy,
      "tick after stop had an effect")

endmodule
